// ----- rtl/clns_pkg.sv -----
// Shared types, codes and reset values for the character LCD nibble sequencer.
// No dependencies; every other file in rtl/ except clns_ifs refers to this package by scoped names.
package clns_pkg;

    // Request kinds.
    localparam logic [1:0] ACT_CMD    = 2'd0;
    localparam logic [1:0] ACT_DATA   = 2'd1;
    localparam logic [1:0] ACT_CURSOR = 2'd2;
    localparam logic [1:0] ACT_LIGHT  = 2'd3;

    // Controller commands that need the long wait afterwards.
    localparam logic [7:0] CMD_CLEAR = 8'h01;
    localparam logic [7:0] CMD_HOME  = 8'h02;

    // Configuration register indexes.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam logic [CFG_IDX_W-1:0] CFG_DEV_ADDR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DRV_EN   = 2'd3;

    // Configuration reset values.
    localparam logic [6:0] RST_DEV_ADDR = 7'd39;
    localparam logic [4:0] RST_COLUMNS  = 5'd16;
    localparam logic [2:0] RST_ROWS     = 3'd2;

    // Depth of the queue between front and back end.
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [6:0] dev_addr;
        logic [4:0] columns;
        logic [2:0] rows;
        logic       drv_en;
    } t_cfg;

    // One queued job. A single job writes data as one expander byte;
    // otherwise data is split into two nibbles of three writes each.
    typedef struct packed {
        logic       single;
        logic       rs;
        logic       bl;
        logic       long_wait;
        logic [7:0] data;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ----- rtl/clns_ifs.sv -----
// Handshake channels of the nibble sequencer: the request word and the expander write word.
// Depends on nothing; payload widths follow the block's field list.
interface clns_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] byte_value;
    logic [7:0] column;
    logic [7:0] row;
    logic       light_on;

    modport source (output valid, action, byte_value, column, row, light_on, input ready);
    modport sink (input valid, action, byte_value, column, row, light_on, output ready);
endinterface

interface clns_wr_if;
    logic       valid;
    logic       ready;
    logic [7:0] expander_byte;
    logic [7:0] write_address;
    logic       long_wait;
    logic       last;

    modport source (output valid, expander_byte, write_address, long_wait, last, input ready);
    modport sink (input valid, expander_byte, write_address, long_wait, last, output ready);
endinterface

// ----- rtl/char_lcd_nibble_sequencer.sv -----
// Top level of the character LCD nibble sequencer: config registers, front end, queue, back end.
// Depends on clns_pkg, clns_ifs, clns_front, clns_queue and clns_back.
//
//  Channel   | Direction | Word
//  i_req     | in        | action, byte_value, column, row, light_on
//  o_wr      | out       | expander_byte, write_address, long_wait, last
//  i_cfg_*   | in        | write enable, register index, register data
//
// The front end takes one request word per cycle while the queue has room.
// The back end issues one expander write per cycle while the output is taken:
// a byte request takes six writes, four or five when an opening nibble write
// repeats the previous byte; a backlight request takes one, none if repeated,
// and none with the driver disabled. Reset is synchronous and needs no clearing
// pass; a stalled output word holds in its register while the queue fills.
module char_lcd_nibble_sequencer #(
    parameter int QUEUE_DEPTH = clns_pkg::QUEUE_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    clns_req_if.sink                       i_req,
    clns_wr_if.source                      o_wr,
    input  logic                           i_cfg_we,
    input  logic [clns_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [clns_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    clns_pkg::t_cfg    r_cfg;
    clns_pkg::t_q_stat q_stat;
    clns_pkg::t_entry  push_entry;
    clns_pkg::t_entry  head_entry;
    logic              push;
    logic              pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dev_addr <= clns_pkg::RST_DEV_ADDR;
            r_cfg.columns  <= clns_pkg::RST_COLUMNS;
            r_cfg.rows     <= clns_pkg::RST_ROWS;
            r_cfg.drv_en   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                clns_pkg::CFG_DEV_ADDR: r_cfg.dev_addr <= i_cfg_data[6:0];
                clns_pkg::CFG_COLUMNS:  r_cfg.columns  <= i_cfg_data[4:0];
                clns_pkg::CFG_ROWS:     r_cfg.rows     <= i_cfg_data[2:0];
                clns_pkg::CFG_DRV_EN:   r_cfg.drv_en   <= i_cfg_data[0];
                default: r_cfg <= r_cfg;
            endcase
        end
    end

    clns_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_cfg    (r_cfg),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_entry  (push_entry)
    );

    clns_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_head  (head_entry),
        .o_stat  (q_stat)
    );

    clns_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_head   (head_entry),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_wr     (o_wr)
    );

`ifndef SYNTHESIS
    // The long wait only ever closes a command: last write, RS low, enable low.
    a_wait_on_cmd_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_wr.valid && o_wr.long_wait) |->
            (o_wr.last && !o_wr.expander_byte[0] && !o_wr.expander_byte[2]))
        else $error("long wait flagged on a write that does not end a command");

    a_queue_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue reports full and empty at once");

    // A job pushed into an idle queue must show up at the head next cycle.
    a_push_visible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> !q_stat.empty)
        else $error("pushed job not visible in the queue");
`endif

endmodule

// ----- rtl/clns_front.sv -----
// Front end: accepts request words, clamps cursor moves and turns each request into a job.
// Depends on clns_pkg and clns_req_if; tracks the backlight bit in request order.
module clns_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    clns_req_if.sink          i_req,
    input  clns_pkg::t_cfg    i_cfg,
    input  clns_pkg::t_q_stat i_q_stat,
    output logic              o_push,
    output clns_pkg::t_entry  o_entry
);

    localparam logic [6:0] ROW_BASE [4] = '{7'h00, 7'h40, 7'h14, 7'h54};

    logic       r_bl;
    logic       n_bl;
    logic [2:0] nr;
    logic [1:0] row_sel;
    logic [4:0] nc;
    logic [4:0] col_sel;
    logic [6:0] cursor_addr;

    assign i_req.ready = !i_q_stat.full;
    assign o_push      = i_req.valid && !i_q_stat.full;

    // Cursor clamping: zero geometry acts as one, more than four rows as four.
    always_comb begin
        if (i_cfg.rows == 3'd0) begin
            nr = 3'd1;
        end else if (i_cfg.rows > 3'd4) begin
            nr = 3'd4;
        end else begin
            nr = i_cfg.rows;
        end
        nc = (i_cfg.columns == 5'd0) ? 5'd1 : i_cfg.columns;

        if (i_req.row >= {5'd0, nr}) begin
            row_sel = 2'(nr - 3'd1);
        end else begin
            row_sel = i_req.row[1:0];
        end
        if (i_req.column >= {3'd0, nc}) begin
            col_sel = nc - 5'd1;
        end else begin
            col_sel = i_req.column[4:0];
        end
        cursor_addr = ROW_BASE[row_sel] + {2'd0, col_sel};
    end

    always_comb begin
        o_entry.single    = 1'b0;
        o_entry.rs        = 1'b0;
        o_entry.bl        = r_bl;
        o_entry.long_wait = 1'b0;
        o_entry.data      = i_req.byte_value;
        n_bl              = r_bl;
        case (i_req.action)
            clns_pkg::ACT_CMD: begin
                o_entry.long_wait = (i_req.byte_value == clns_pkg::CMD_CLEAR)
                                 || (i_req.byte_value == clns_pkg::CMD_HOME);
            end
            clns_pkg::ACT_DATA: begin
                o_entry.rs = 1'b1;
            end
            clns_pkg::ACT_CURSOR: begin
                o_entry.data = {1'b1, cursor_addr};
            end
            clns_pkg::ACT_LIGHT: begin
                o_entry.single = 1'b1;
                o_entry.bl     = i_req.light_on;
                o_entry.data   = {4'd0, i_req.light_on, 3'd0};
                n_bl           = i_req.light_on;
            end
            default: begin
                o_entry.single = 1'b0;
            end
        endcase
    end

    // The backlight bit changes even when the driver is disabled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bl <= 1'b1;
        end else if (o_push) begin
            r_bl <= n_bl;
        end
    end

endmodule

// ----- rtl/clns_queue.sv -----
// Small job queue between the front and back end of the nibble sequencer.
// Depends on clns_pkg for the job and status types.
module clns_queue #(
    parameter int DEPTH = clns_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  clns_pkg::t_entry  i_entry,
    input  logic              i_pop,
    output clns_pkg::t_entry  o_head,
    output clns_pkg::t_q_stat o_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    clns_pkg::t_entry r_slots [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_head       = r_slots[r_rd_ptr];
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slots[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/clns_back.sv -----
// Back end: steps each job through its expander writes, drops repeats, registers the output word.
// Depends on clns_pkg and clns_wr_if; holds the last written expander byte.
module clns_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  clns_pkg::t_cfg    i_cfg,
    input  clns_pkg::t_entry  i_head,
    input  clns_pkg::t_q_stat i_q_stat,
    output logic              o_pop,
    clns_wr_if.source         o_wr
);

    localparam logic [2:0] LAST_STEP = 3'd5;
    localparam logic [7:0] PIN_EN    = 8'h04;

    logic [2:0] r_step;
    logic [2:0] n_step;
    logic [7:0] r_last;
    logic       r_ov;
    logic [7:0] r_byte;
    logic       r_wait;
    logic       r_final;

    logic       slot_free;
    logic       go;
    logic       emit;
    logic       fin;
    logic       wt;
    logic [7:0] wbyte;
    logic [7:0] hi_w;
    logic [7:0] lo_w;
    logic [7:0] w_cur;
    logic [2:0] eff;

    // Byte at a given step: high nibble plain, enabled, plain; then the low nibble.
    function automatic logic [7:0] step_byte(input logic [7:0] hi, input logic [7:0] lo,
                                             input logic [2:0] s);
        logic [7:0] v;
        v = (s < 3'd3) ? hi : lo;
        if (s == 3'd1 || s == 3'd4) begin
            v = v | PIN_EN;
        end
        return v;
    endfunction

    assign hi_w = {i_head.data[7:4], i_head.bl, 2'b00, i_head.rs};
    assign lo_w = {i_head.data[3:0], i_head.bl, 2'b00, i_head.rs};

    // Only a step that opens a nibble can repeat the previous byte, and the step
    // after it never does, so a repeat is skipped within the same cycle.
    assign w_cur = step_byte(hi_w, lo_w, r_step);
    assign eff   = (w_cur == r_last) ? r_step + 3'd1 : r_step;

    assign slot_free = !r_ov || o_wr.ready;
    assign go        = !i_q_stat.empty && slot_free;

    always_comb begin
        o_pop  = 1'b0;
        emit   = 1'b0;
        fin    = 1'b0;
        wt     = 1'b0;
        wbyte  = step_byte(hi_w, lo_w, eff);
        n_step = r_step;
        if (go) begin
            if (!i_cfg.drv_en) begin
                o_pop = 1'b1;
            end else if (i_head.single) begin
                o_pop = 1'b1;
                wbyte = i_head.data;
                emit  = (i_head.data != r_last);
                fin   = 1'b1;
            end else begin
                emit = 1'b1;
                if (eff == LAST_STEP) begin
                    fin    = 1'b1;
                    wt     = i_head.long_wait;
                    o_pop  = 1'b1;
                    n_step = 3'd0;
                end else begin
                    n_step = eff + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= 3'd0;
            r_last <= 8'hFF;
            r_ov   <= 1'b0;
        end else begin
            r_step <= n_step;
            if (emit) begin
                r_last <= wbyte;
            end
            if (slot_free) begin
                r_ov <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_byte  <= wbyte;
            r_wait  <= wt;
            r_final <= fin;
        end
    end

    assign o_wr.valid         = r_ov;
    assign o_wr.expander_byte = r_byte;
    assign o_wr.write_address = {i_cfg.dev_addr, 1'b0};
    assign o_wr.long_wait     = r_wait;
    assign o_wr.last          = r_final;

endmodule
